// File: rtl/core/integer_to_radix_text_assert.svh
// ----------------------------------------------------------------------------
// Integer to radix text: assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define INTEGER_TO_RADIX_TEXT_ASSERT_SVH

// Same-cycle implication.
`define ITRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ITRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/itrt_pkg.sv
// ----------------------------------------------------------------------------
// Integer to radix text: shared package
// Widths, character codes, control/status structs and digit helpers.
// ----------------------------------------------------------------------------
package itrt_pkg;

   localparam int VALUE_W       = 32;
   localparam int RADIX_W       = 6;
   localparam int CHAR_W        = 8;
   localparam int DIV_STEP_BITS = 8;

   localparam int MAX_DIGITS_DEF = 32;
   localparam int VALUE_BITS_DEF = 32;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_TEN = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 8'd87;
   localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_UNDER     = 8'd95;
   localparam logic [CHAR_W-1:0] CHAR_NONE      = 8'd0;

   typedef enum logic [2:0] {
      OUT_BAD,
      OUT_MINUS,
      OUT_DIGIT,
      OUT_UNDER,
      OUT_TENS,
      OUT_ONES
   } out_sel_type;

   typedef struct packed {
      logic        load;
      logic        step;
      logic        rd;
      logic        emit;
      out_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic bad_radix;
      logic div_done;
      logic cnt_zero;
      logic neg;
      logic radix_ten;
      logic radix_ge10;
   } dp_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = CHAR_W'(d);
      if (d < RADIX_TEN) begin
         return dx + CHAR_ZERO;
      end
      return dx + CHAR_ALPHA_OFS;
   endfunction

   function automatic logic [3:0] radix_tens(input logic [RADIX_W-1:0] r);
      if (r >= 6'd60) begin
         return 4'd6;
      end else if (r >= 6'd50) begin
         return 4'd5;
      end else if (r >= 6'd40) begin
         return 4'd4;
      end else if (r >= 6'd30) begin
         return 4'd3;
      end else if (r >= 6'd20) begin
         return 4'd2;
      end else if (r >= 6'd10) begin
         return 4'd1;
      end
      return 4'd0;
   endfunction

   function automatic logic [3:0] radix_ones(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] tens_x10;
      tens_x10 = RADIX_W'(radix_tens(r) * 4'd10);
      return 4'(r - tens_x10);
   endfunction

endpackage

// File: rtl/core/itrt_datapath.sv
// ----------------------------------------------------------------------------
// Integer to radix text: datapath
// Magnitude register, chunked long divider, digit store and result register.
// ----------------------------------------------------------------------------
module itrt_datapath #(
   parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = itrt_pkg::MAX_DIGITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  itrt_pkg::dp_cmd_type                  cmd,
   output itrt_pkg::dp_status_type               status,
   input  logic signed [itrt_pkg::VALUE_W-1:0]   req_value,
   input  logic        [itrt_pkg::RADIX_W-1:0]   req_radix,
   output logic                                  rsp_strobe,
   output logic        [itrt_pkg::CHAR_W-1:0]    rsp_char_code,
   output logic                                  rsp_last,
   output logic                                  rsp_bad_radix
);

   localparam int STEP   = itrt_pkg::DIV_STEP_BITS;
   localparam int RW     = itrt_pkg::RADIX_W;
   localparam int NCHUNK = (VALUE_BITS + STEP - 1) / STEP;
   localparam int MAG_W  = NCHUNK * STEP;
   localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int AW     = $clog2(MAX_DIGITS);
   localparam int CW     = $clog2(MAX_DIGITS + 1);

   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [RW-1:0]     radix_ff, radix_in;
   logic              neg_ff, neg_in;
   logic [CKW-1:0]    chunk_ff, chunk_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [RW-1:0]     rd_data_ff;
   logic [RW-1:0]     store_mem [MAX_DIGITS];

   logic [VALUE_BITS-1:0] val_v;
   logic [VALUE_BITS-1:0] mag_v;
   logic [RW-1:0]         rem_step;
   logic [STEP-1:0]       q_step;
   logic                  last_chunk;
   logic                  wr_en;
   logic [CW-1:0]         cnt_dec;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;

   logic                          strobe_ff;
   logic [itrt_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic                          last_ff, last_in;
   logic                          bad_ff, bad_in;

   assign val_v      = VALUE_BITS'($unsigned(req_value));
   assign mag_v      = val_v[VALUE_BITS-1] ? (~val_v + VALUE_BITS'(1)) : val_v;
   assign last_chunk = (chunk_ff == CKW'(NCHUNK - 1));
   assign wr_en      = cmd.step && last_chunk && (cnt_ff < CW'(MAX_DIGITS));
   assign wr_addr    = cnt_ff[AW-1:0];
   assign cnt_dec    = cnt_ff - CW'(1);
   assign rd_addr    = cnt_dec[AW-1:0];

   // one chunk of restoring long division, most significant bit first
   always_comb begin
      logic [RW:0]   t;
      logic [RW-1:0] r;
      logic [STEP-1:0] q;
      r = rem_ff;
      q = '0;
      for (int i = 0; i < STEP; i++) begin
         t = {r, mag_ff[MAG_W-1-i]};
         if (t >= {1'b0, radix_ff}) begin
            t = t - {1'b0, radix_ff};
            q[STEP-1-i] = 1'b1;
         end
         r = t[RW-1:0];
      end
      rem_step = r;
      q_step   = q;
   end

   always_comb begin
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      chunk_in = chunk_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         mag_in   = MAG_W'(mag_v);
         rem_in   = '0;
         radix_in = req_radix;
         neg_in   = val_v[VALUE_BITS-1];
         chunk_in = '0;
         cnt_in   = '0;
      end else if (cmd.step) begin
         mag_in = (mag_ff << STEP) | MAG_W'(q_step);
         if (last_chunk) begin
            rem_in   = '0;
            chunk_in = '0;
            if (wr_en) begin
               cnt_in = cnt_ff + CW'(1);
            end
         end else begin
            rem_in   = rem_step;
            chunk_in = chunk_ff + CKW'(1);
         end
      end else if (cmd.rd) begin
         cnt_in = cnt_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff   <= '0;
         rem_ff   <= '0;
         radix_ff <= '0;
         neg_ff   <= 1'b0;
         chunk_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         mag_ff   <= mag_in;
         rem_ff   <= rem_in;
         radix_ff <= radix_in;
         neg_ff   <= neg_in;
         chunk_ff <= chunk_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= rem_step;
      end
      if (cmd.rd) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_comb begin
      status.bad_radix  = !(radix_ff inside {[itrt_pkg::RADIX_MIN:itrt_pkg::RADIX_MAX]});
      status.div_done   = (chunk_ff == '0) && (mag_ff == '0) && (cnt_ff != '0);
      status.cnt_zero   = (cnt_ff == '0);
      status.neg        = neg_ff;
      status.radix_ten  = (radix_ff == itrt_pkg::RADIX_TEN);
      status.radix_ge10 = (radix_ff >= itrt_pkg::RADIX_TEN);
   end

   always_comb begin
      char_in = itrt_pkg::CHAR_NONE;
      last_in = 1'b0;
      bad_in  = 1'b0;
      case (cmd.sel)
         itrt_pkg::OUT_BAD: begin
            last_in = 1'b1;
            bad_in  = 1'b1;
         end
         itrt_pkg::OUT_MINUS: begin
            char_in = itrt_pkg::CHAR_MINUS;
         end
         itrt_pkg::OUT_DIGIT: begin
            char_in = itrt_pkg::digit_char(rd_data_ff);
            last_in = status.cnt_zero && status.radix_ten;
         end
         itrt_pkg::OUT_UNDER: begin
            char_in = itrt_pkg::CHAR_UNDER;
         end
         itrt_pkg::OUT_TENS: begin
            char_in = itrt_pkg::CHAR_ZERO + itrt_pkg::CHAR_W'(itrt_pkg::radix_tens(radix_ff));
         end
         itrt_pkg::OUT_ONES: begin
            char_in = itrt_pkg::CHAR_ZERO + itrt_pkg::CHAR_W'(itrt_pkg::radix_ones(radix_ff));
            last_in = 1'b1;
         end
         default: begin
            char_in = itrt_pkg::CHAR_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
      char_ff <= char_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_bad_radix = bad_ff;

endmodule

// File: rtl/core/itrt_ctrl.sv
// ----------------------------------------------------------------------------
// Integer to radix text: controller
// Sequences check, division, digit readout and suffix for one word.
// ----------------------------------------------------------------------------
module itrt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output itrt_pkg::dp_cmd_type    cmd,
   input  itrt_pkg::dp_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_PREP,
      ST_SIGN,
      ST_DIGITS,
      ST_UNDER,
      ST_TENS,
      ST_ONES
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '{load: 1'b0, step: 1'b0, rd: 1'b0, emit: 1'b0, sel: itrt_pkg::OUT_BAD};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.bad_radix) begin
               cmd.emit = 1'b1;
               cmd.sel  = itrt_pkg::OUT_BAD;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_PREP;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_PREP: begin
            cmd.rd   = 1'b1;
            state_in = status.neg ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            cmd.emit = 1'b1;
            cmd.sel  = itrt_pkg::OUT_MINUS;
            state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            cmd.emit = 1'b1;
            cmd.sel  = itrt_pkg::OUT_DIGIT;
            if (!status.cnt_zero) begin
               cmd.rd = 1'b1;
            end else begin
               state_in = status.radix_ten ? ST_IDLE : ST_UNDER;
            end
         end
         ST_UNDER: begin
            cmd.emit = 1'b1;
            cmd.sel  = itrt_pkg::OUT_UNDER;
            state_in = status.radix_ge10 ? ST_TENS : ST_ONES;
         end
         ST_TENS: begin
            cmd.emit = 1'b1;
            cmd.sel  = itrt_pkg::OUT_TENS;
            state_in = ST_ONES;
         end
         ST_ONES: begin
            cmd.emit = 1'b1;
            cmd.sel  = itrt_pkg::OUT_ONES;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// File: rtl/core/integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// Integer to radix text
// Converts a signed word to ASCII text in radix 2..36: an optional '-', the
// digits most significant first ('0'-'9', 'a'-'z'), then '_' and the radix in
// decimal unless the radix is ten; rsp_last marks the final character. A
// radix outside 2..36 gives one result with char 0, last and bad_radix set.
// A word is taken when start is high and busy is low. Results appear one per
// cycle on rsp_strobe and cannot be held off. Per word the block does one
// radix check, then for each digit ceil(VALUE_BITS/8) steps of the long
// divider (which retires 8 quotient bits a cycle), one step to see the
// quotient at zero and one digit store read, then emits one character per
// cycle and returns to idle. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "integer_to_radix_text_assert.svh"

module integer_to_radix_text #(
   parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = itrt_pkg::MAX_DIGITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [itrt_pkg::VALUE_W-1:0] req_value,
   input  logic        [itrt_pkg::RADIX_W-1:0] req_radix,
   output logic                                rsp_strobe,
   output logic        [itrt_pkg::CHAR_W-1:0]  rsp_char_code,
   output logic                                rsp_last,
   output logic                                rsp_bad_radix
);

   itrt_pkg::dp_cmd_type    cmd;
   itrt_pkg::dp_status_type status;

   itrt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   itrt_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_bad_radix (rsp_bad_radix)
   );

   `ITRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepted word")
   `ITRT_ASSERT_NEXT(a_accept_quiet, start && !busy, !rsp_strobe, "result right after accept")
   `ITRT_ASSERT_NEXT(a_last_gap, rsp_strobe && rsp_last, !rsp_strobe, "result after last")
   `ITRT_ASSERT_NOW(a_bad_shape, rsp_strobe && rsp_bad_radix, rsp_last && (rsp_char_code == '0), "bad radix result malformed")
   `ITRT_ASSERT_NOW(a_no_cmd_clash, cmd.step || cmd.rd || cmd.load, !(cmd.step && cmd.rd) && !(cmd.load && (cmd.step || cmd.rd)), "conflicting datapath commands")

endmodule

// File: tb/sv/integer_to_radix_text_tb.sv
// ----------------------------------------------------------------------------
// Integer to radix text: testbench
// Sends signed words with radices from 0 to 63 and checks every character
// that comes back, in order, against a local prediction of the text: the
// sign, the digits most significant first, the '_' radix suffix, the last
// mark and the bad radix flag. Directed words cover zero, the extremes and
// the bad radices; random words follow, most with bursts of sender idling.
// ----------------------------------------------------------------------------
module integer_to_radix_text_tb;

   localparam int MAX_REPORTS    = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 10;

   localparam logic [itrt_pkg::VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [itrt_pkg::VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [itrt_pkg::CHAR_W-1:0] code;
      logic                        last;
      logic                        bad;
   } text_char_type;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                start     = 1'b0;
   logic signed [itrt_pkg::VALUE_W-1:0] req_value = '0;
   logic        [itrt_pkg::RADIX_W-1:0] req_radix = '0;
   logic                                busy;
   logic                                rsp_strobe;
   logic        [itrt_pkg::CHAR_W-1:0]  rsp_char_code;
   logic                                rsp_last;
   logic                                rsp_bad_radix;

   text_char_type pending_chars[$];
   int            fail_count   = 0;
   int            stall_cycles = 0;
   int            gap_odds     = 0;

   integer_to_radix_text DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_radix     (req_radix),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_bad_radix (rsp_bad_radix)
   );

   always #2 clock = ~clock;

   function automatic void push_char(input logic [itrt_pkg::CHAR_W-1:0] code,
                                     input logic last, input logic bad);
      text_char_type c;
      c.code = code;
      c.last = last;
      c.bad  = bad;
      pending_chars.push_back(c);
   endfunction

   function automatic void predict_text(input logic [itrt_pkg::VALUE_W-1:0] value,
                                        input logic [itrt_pkg::RADIX_W-1:0] radix);
      logic [itrt_pkg::VALUE_W-1:0] mag;
      logic [itrt_pkg::RADIX_W-1:0] digits [0:itrt_pkg::VALUE_W-1];
      logic [itrt_pkg::RADIX_W-1:0] tens;
      logic                         neg;
      int                           count;
      if (radix < itrt_pkg::RADIX_MIN || radix > itrt_pkg::RADIX_MAX) begin
         push_char(itrt_pkg::CHAR_NONE, 1'b1, 1'b1);
         return;
      end
      neg   = value[itrt_pkg::VALUE_W-1];
      mag   = neg ? -value : value;
      count = 0;
      do begin
         digits[count] = itrt_pkg::RADIX_W'(mag % radix);
         mag           = mag / radix;
         count++;
      end while (mag != 0);
      if (neg) begin
         push_char(itrt_pkg::CHAR_MINUS, 1'b0, 1'b0);
      end
      for (int i = count - 1; i >= 0; i--) begin
         push_char((digits[i] < itrt_pkg::RADIX_TEN)
                      ? itrt_pkg::CHAR_ZERO + itrt_pkg::CHAR_W'(digits[i])
                      : itrt_pkg::CHAR_ALPHA_OFS + itrt_pkg::CHAR_W'(digits[i]),
                   (i == 0) && (radix == itrt_pkg::RADIX_TEN), 1'b0);
      end
      if (radix != itrt_pkg::RADIX_TEN) begin
         push_char(itrt_pkg::CHAR_UNDER, 1'b0, 1'b0);
         tens = radix / itrt_pkg::RADIX_TEN;
         if (tens != 0) begin
            push_char(itrt_pkg::CHAR_ZERO + itrt_pkg::CHAR_W'(tens), 1'b0, 1'b0);
         end
         push_char(itrt_pkg::CHAR_ZERO + itrt_pkg::CHAR_W'(radix % itrt_pkg::RADIX_TEN),
                   1'b1, 1'b0);
      end
   endfunction

   task automatic send_word(input logic [itrt_pkg::VALUE_W-1:0] value,
                            input logic [itrt_pkg::RADIX_W-1:0] radix);
      if (gap_odds != 0 && $urandom_range(1, 4) <= gap_odds) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      req_radix <= radix;
      do @(posedge clock); while (busy);
      predict_text(value, radix);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   task automatic test_special_values();
      send_word('0, 6'd10);
      send_word('0, 6'd2);
      send_word('0, 6'd36);
      send_word(32'd1, 6'd10);
      send_word(-32'sd1, 6'd10);
      send_word(VALUE_MAX, 6'd2);
      send_word(VALUE_MIN, 6'd2);
      send_word(VALUE_MIN, 6'd10);
      send_word(VALUE_MIN, 6'd36);
      send_word(VALUE_MAX, 6'd36);
      send_word(VALUE_MIN, 6'd16);
   endtask

   task automatic test_bad_radix();
      send_word(32'd5, 6'd0);
      send_word(-32'sd9, 6'd1);
      send_word('0, 6'd37);
      send_word(VALUE_MAX, 6'd63);
   endtask

   task automatic test_radix_suffix();
      send_word(32'd35, 6'd36);
      send_word(32'd1295, 6'd35);
      send_word(-32'sd255, 6'd16);
      send_word(32'd123, 6'd9);
      send_word(32'd100, 6'd11);
      send_word(-32'sd999, 6'd20);
      send_word(32'd7, 6'd3);
   endtask

   task automatic test_random_words(input int count, input bit idle);
      logic [itrt_pkg::VALUE_W-1:0] value;
      logic [itrt_pkg::RADIX_W-1:0] radix;
      for (int n = 0; n < count; n++) begin
         if (n % 25 == 0) begin
            gap_odds = idle ? $urandom_range(0, 3) : 0;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: value = $urandom;
            4, 5, 6:    value = $urandom >> $urandom_range(1, 31);
            7:          value = $urandom_range(0, 40);
            default: begin
               case ($urandom_range(0, 3))
                  0:       value = '0;
                  1:       value = VALUE_MIN;
                  2:       value = VALUE_MAX;
                  default: value = '1;
               endcase
            end
         endcase
         if ($urandom_range(0, 1) == 1 && value != VALUE_MIN) begin
            value = -value;
         end
         if ($urandom_range(0, 9) == 0) begin
            radix = itrt_pkg::RADIX_W'($urandom_range(0, 63));
         end else begin
            radix = itrt_pkg::RADIX_W'($urandom_range(itrt_pkg::RADIX_MIN,
                                                      itrt_pkg::RADIX_MAX));
         end
         send_word(value, radix);
      end
   endtask

   task automatic test_pause_until_drained();
      logic [itrt_pkg::RADIX_W-1:0] radix;
      repeat (2) begin
         radix = itrt_pkg::RADIX_W'($urandom_range(itrt_pkg::RADIX_MIN,
                                                   itrt_pkg::RADIX_MAX));
         send_word($urandom, radix);
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_strobe) begin
         if (pending_chars.size() == 0) begin
            if (fail_count < MAX_REPORTS) begin
               $display("unexpected char: code %0d last %0b bad_radix %0b",
                        rsp_char_code, rsp_last, rsp_bad_radix);
            end
            fail_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_char_code !== want.code || rsp_last !== want.last
                || rsp_bad_radix !== want.bad) begin
               if (fail_count < MAX_REPORTS) begin
                  $display("char mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                           want.code, want.last, want.bad,
                           rsp_char_code, rsp_last, rsp_bad_radix);
               end
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset    <= 1'b0;
      @(posedge clock);
      gap_odds = 2;
      test_special_values();
      test_bad_radix();
      test_radix_suffix();
      test_random_words(150, 1'b1);
      test_pause_until_drained();
      test_random_words(80, 1'b1);
      test_random_words(60, 1'b0);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
